/* rtl/imt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// imt_pkg
// Shared constants and types for the interval map table.
// ----------------------------------------------------------------------------
package imt_pkg;

  localparam int MaxEntries = 64;
  localparam int KeyBits    = 16;
  localparam int ValueBits  = 8;
  localparam int IdxBits    = $clog2(MaxEntries);
  localparam int CntBits    = $clog2(MaxEntries + 1);
  localparam int WrkDepth   = MaxEntries + 2;
  localparam int WrkBits    = $clog2(WrkDepth + 1);

  localparam logic ActAssign = 1'b0;
  localparam logic ActLookup = 1'b1;

  typedef logic [KeyBits-1:0]   key_t;
  typedef logic [ValueBits-1:0] val_t;
  typedef logic [CntBits-1:0]   cnt_t;
  typedef logic [WrkBits-1:0]   wcnt_t;

  // Datapath operation codes issued by the controller.
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,     // latch item, clear counters
    OP_SCAN,     // read table entry at rd index
    OP_COPY,     // move one read entry into work store
    OP_PUSH,     // push an explicit (key, value) into work store
    OP_CANON,    // canonicalize one work entry
    OP_WBACK     // copy one work entry back into table
  } op_t;

  typedef struct packed {
    op_t  op;
    logic push_end;   // for OP_PUSH: push (end, end_value) instead of (begin, v)
    logic rd_next;    // advance table read index
    logic rd_clear;   // rewind table read index to the first entry
    logic commit;     // write back final count
    logic respond;    // emit result
    logic full;       // flag refusal in result
  } cmd_t;

  typedef struct packed {
    logic rd_valid;   // rd index < count
    logic rd_lt_b;    // entry key < begin
    logic rd_le_key;  // entry key <= lookup key
    logic rd_lt_e;    // entry key < end
    logic rd_eq_e;    // entry key == end
    logic empty;      // begin >= end
    logic lookup;     // item is a lookup
    logic wk_done;    // canon index reached work count
    logic wb_done;    // writeback index reached canon count
    logic over;       // canon count > MaxEntries
  } sts_t;

endpackage
`default_nettype wire

/* rtl/interval_map_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// interval_map_table
// Sorted breakpoint table with range assign and point lookup.
//
//  channel  | ports                                          | handshake
//  input    | in_action, in_range_*, in_assign_value, in_lookup_key | start/busy
//  result   | out_lookup_value, out_table_full, out_entry_count | out_valid
//  config   | cfg_we, cfg_wdata (initial value)              | write enable
//
// A lookup walks the breakpoints at or below the key, from accept to result
// beat; an empty assign stops after the first check. A non-empty assign walks
// the table twice (value at end, then copy and skip), then canonicalizes and
// writes back the work entries; the single read port of each memory sets the
// pace. A refused assign skips writeback.
// Reset is synchronous; the table is empty after reset, no clearing pass.
// Results are shown for one cycle on out_valid; the receiver cannot stall.
// ----------------------------------------------------------------------------
module interval_map_table (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                in_action,
  input  wire imt_pkg::key_t       in_range_begin,
  input  wire imt_pkg::key_t       in_range_end,
  input  wire imt_pkg::val_t       in_assign_value,
  input  wire imt_pkg::key_t       in_lookup_key,
  output logic                     out_valid,
  output imt_pkg::val_t            out_lookup_value,
  output logic                     out_table_full,
  output imt_pkg::cnt_t            out_entry_count,
  input  wire logic                cfg_we,
  input  wire imt_pkg::val_t       cfg_wdata
);

  imt_pkg::cmd_t cmd;
  imt_pkg::sts_t sts;
  imt_pkg::val_t init_r;

  always_ff @(posedge clk) begin
    if (!rst_n) init_r <= '0;
    else if (cfg_we) init_r <= cfg_wdata;
  end

  imt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  imt_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_action(in_action), .in_range_begin(in_range_begin),
    .in_range_end(in_range_end), .in_assign_value(in_assign_value),
    .in_lookup_key(in_lookup_key), .init_val(init_r),
    .out_lookup_value(out_lookup_value), .out_table_full(out_table_full),
    .out_entry_count(out_entry_count), .out_valid(out_valid)
  );

endmodule
`default_nettype wire

/* rtl/imt_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// imt_datapath
// Breakpoint table, work store, counters and compares.
// ----------------------------------------------------------------------------
module imt_datapath (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire imt_pkg::cmd_t  cmd,
  output imt_pkg::sts_t       sts,
  input  wire logic           in_action,
  input  wire imt_pkg::key_t  in_range_begin,
  input  wire imt_pkg::key_t  in_range_end,
  input  wire imt_pkg::val_t  in_assign_value,
  input  wire imt_pkg::key_t  in_lookup_key,
  input  wire imt_pkg::val_t  init_val,
  output imt_pkg::val_t       out_lookup_value,
  output logic                out_table_full,
  output imt_pkg::cnt_t       out_entry_count,
  output logic                out_valid
);

  // table memory, one read port registered
  imt_pkg::key_t tkey_mem [imt_pkg::MaxEntries];
  imt_pkg::val_t tval_mem [imt_pkg::MaxEntries];
  // work memory
  imt_pkg::key_t wkey_mem [imt_pkg::WrkDepth];
  imt_pkg::val_t wval_mem [imt_pkg::WrkDepth];

  logic          act_r;
  imt_pkg::key_t b_r, e_r, k_r;
  imt_pkg::val_t v_r;
  imt_pkg::cnt_t count_r;
  imt_pkg::cnt_t rd_r;
  imt_pkg::key_t rkey_r;
  imt_pkg::val_t rval_r;
  imt_pkg::val_t lv_r, ev_r, prev_r;
  imt_pkg::wcnt_t wn_r, wj_r, wm_r, wb_r;
  imt_pkg::key_t wrd_key_r;
  imt_pkg::val_t wrd_val_r;
  logic          wq_ok_r;

  imt_pkg::val_t out_val_r;
  logic          out_full_r, out_valid_r;

  logic rd_valid;
  assign rd_valid = ({1'b0, rd_r} < {1'b0, count_r}) && (rd_r != '0 || count_r != '0);

  // Work memory read address: canon reads at wj, writeback reads at wb.
  imt_pkg::wcnt_t wraddr;
  assign wraddr = (cmd.op == imt_pkg::OP_WBACK) ? wb_r : wj_r;

  always_ff @(posedge clk) begin
    rkey_r <= tkey_mem[rd_r[imt_pkg::IdxBits-1:0]];
    rval_r <= tval_mem[rd_r[imt_pkg::IdxBits-1:0]];
    if (wraddr < imt_pkg::WrkBits'(imt_pkg::WrkDepth)) begin
      wrd_key_r <= wkey_mem[wraddr];
      wrd_val_r <= wval_mem[wraddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_r        <= '0;
      wn_r        <= '0;
      wj_r        <= '0;
      wm_r        <= '0;
      wb_r        <= '0;
      wq_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_full_r  <= 1'b0;
      out_val_r   <= '0;
    end else begin
      out_valid_r <= cmd.respond;
      // a work read issued this cycle is consumed in the next one
      wq_ok_r     <= ((cmd.op == imt_pkg::OP_CANON) && (wj_r != wn_r)) ||
                     ((cmd.op == imt_pkg::OP_WBACK) && (wb_r != wm_r));
      if (cmd.op == imt_pkg::OP_LOAD || cmd.rd_clear) rd_r <= '0;
      else if (cmd.rd_next || (cmd.op == imt_pkg::OP_WBACK && wq_ok_r))
        rd_r <= rd_r + 1'b1;
      unique case (cmd.op)
        imt_pkg::OP_LOAD: begin
          act_r <= in_action;
          b_r   <= in_range_begin;
          e_r   <= in_range_end;
          v_r   <= in_assign_value;
          k_r   <= in_lookup_key;
          wn_r  <= '0;
          wj_r  <= '0;
          wm_r  <= '0;
          wb_r  <= '0;
          lv_r  <= init_val;
          ev_r  <= init_val;
          prev_r <= init_val;
        end
        imt_pkg::OP_SCAN: begin
          // track value at lookup key and at end
          if (rd_valid && rkey_r <= k_r) lv_r <= rval_r;
          if (rd_valid && rkey_r <= e_r) ev_r <= rval_r;
        end
        imt_pkg::OP_COPY: begin
          wkey_mem[wn_r[imt_pkg::IdxBits:0]] <= rkey_r;
          wval_mem[wn_r[imt_pkg::IdxBits:0]] <= rval_r;
          wn_r <= wn_r + 1'b1;
        end
        imt_pkg::OP_PUSH: begin
          wkey_mem[wn_r[imt_pkg::IdxBits:0]] <= cmd.push_end ? e_r : b_r;
          wval_mem[wn_r[imt_pkg::IdxBits:0]] <= cmd.push_end ? ev_r : v_r;
          wn_r <= wn_r + 1'b1;
        end
        imt_pkg::OP_CANON: begin
          // first cycle issues read; following cycles consume and issue next
          if (wq_ok_r) begin
            if (wrd_val_r != prev_r) begin
              prev_r <= wrd_val_r;
              wkey_mem[wm_r[imt_pkg::IdxBits:0]] <= wrd_key_r;
              wval_mem[wm_r[imt_pkg::IdxBits:0]] <= wrd_val_r;
              wm_r <= wm_r + 1'b1;
            end
          end
          if (wj_r != wn_r) wj_r <= wj_r + 1'b1;
        end
        imt_pkg::OP_WBACK: begin
          if (wq_ok_r) begin
            tkey_mem[rd_r[imt_pkg::IdxBits-1:0]] <= wrd_key_r;
            tval_mem[rd_r[imt_pkg::IdxBits-1:0]] <= wrd_val_r;
          end
          if (wb_r != wm_r) wb_r <= wb_r + 1'b1;
        end
        default: ;
      endcase
      if (cmd.commit) count_r <= imt_pkg::CntBits'(wm_r);
      if (cmd.respond) begin
        out_full_r <= cmd.full;
        out_val_r  <= (act_r == imt_pkg::ActLookup) ? lv_r : '0;
      end
    end
  end

  always_comb begin
    sts.rd_valid  = rd_valid;
    sts.rd_lt_b   = rkey_r < b_r;
    sts.rd_le_key = rkey_r <= k_r;
    sts.rd_lt_e   = rkey_r < e_r;
    sts.rd_eq_e   = rkey_r == e_r;
    sts.empty     = b_r >= e_r;
    sts.lookup    = act_r == imt_pkg::ActLookup;
    sts.wk_done   = (wj_r == wn_r) && !wq_ok_r;
    sts.wb_done   = (wb_r == wm_r) && !wq_ok_r;
    sts.over      = wm_r > imt_pkg::WrkBits'(imt_pkg::MaxEntries);
  end

  assign out_lookup_value = out_val_r;
  assign out_table_full   = out_full_r;
  assign out_entry_count  = count_r;
  assign out_valid        = out_valid_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= imt_pkg::CntBits'(imt_pkg::MaxEntries))
    else $error("entry count exceeds capacity");
  a_canon_le: assert property (@(posedge clk) disable iff (!rst_n)
    wm_r <= wj_r)
    else $error("canonical count passed scan index");
  a_work_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wn_r <= imt_pkg::WrkBits'(imt_pkg::WrkDepth))
    else $error("work store overflow");

endmodule
`default_nettype wire

/* rtl/imt_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// imt_ctrl
// Sequencer for lookup scan and the assign walk, canonicalize and writeback.
// ----------------------------------------------------------------------------
module imt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire imt_pkg::sts_t sts,
  output imt_pkg::cmd_t      cmd
);

  // Every table read lands in the datapath's registered read port;
  // the *_RD states wait for it.
  typedef enum logic [3:0] {
    S_IDLE, S_LKRD, S_LKCHK, S_EVRD, S_EVCHK, S_PRE_RD, S_PRE, S_SKIP_RD,
    S_SKIP, S_POST_RD, S_POST, S_CANON, S_WBACK, S_DONE, S_FULL
  } state_t;

  state_t state_r;
  logic   endp_r;
  logic   post_first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      endp_r       <= 1'b0;
      post_first_r <= 1'b0;
    end else begin
      // mark the first cycle of the copy-out walk
      post_first_r <= (state_r == S_SKIP) && !(sts.rd_valid && sts.rd_lt_e);
      unique case (state_r)
        S_IDLE:    if (start) state_r <= S_LKRD;
        S_LKRD:    state_r <= S_LKCHK;
        S_LKCHK: begin
          // lookup walk; an assign shares it to find the value at end
          if (sts.lookup) state_r <= sts.rd_valid && sts.rd_le_key ? S_LKRD : S_DONE;
          else if (sts.empty) state_r <= S_DONE;
          else state_r <= S_EVRD;
        end
        S_EVRD:    state_r <= S_EVCHK;
        S_EVCHK:   state_r <= (sts.rd_valid && (sts.rd_lt_e || sts.rd_eq_e)) ? S_EVRD
                                                                            : S_PRE_RD;
        S_PRE_RD:  state_r <= S_PRE;
        S_PRE:     state_r <= (sts.rd_valid && sts.rd_lt_b) ? S_PRE_RD : S_SKIP;
        S_SKIP_RD: state_r <= S_SKIP;
        S_SKIP: begin
          if (sts.rd_valid && sts.rd_lt_e) state_r <= S_SKIP_RD;
          else begin
            endp_r  <= sts.rd_valid && sts.rd_eq_e;
            state_r <= S_POST;
          end
        end
        S_POST_RD: state_r <= S_POST;
        S_POST:    state_r <= sts.rd_valid ? S_POST_RD : S_CANON;
        S_CANON:   if (sts.wk_done) state_r <= sts.over ? S_FULL : S_WBACK;
        S_WBACK:   if (sts.wb_done) state_r <= S_DONE;
        S_DONE:    state_r <= S_IDLE;
        S_FULL:    state_r <= S_IDLE;
        default:   state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.op = imt_pkg::OP_IDLE;
    unique case (state_r)
      S_IDLE:  if (start) cmd.op = imt_pkg::OP_LOAD;
      S_LKCHK: begin
        cmd.op = imt_pkg::OP_SCAN;
        if (sts.lookup && sts.rd_valid && sts.rd_le_key) cmd.rd_next = 1'b1;
      end
      S_EVCHK: begin
        cmd.op = imt_pkg::OP_SCAN;
        // rewind for the copy walk once past the end key
        if (sts.rd_valid && (sts.rd_lt_e || sts.rd_eq_e)) cmd.rd_next = 1'b1;
        else cmd.rd_clear = 1'b1;
      end
      S_PRE: begin
        if (sts.rd_valid && sts.rd_lt_b) begin
          cmd.op = imt_pkg::OP_COPY;
          cmd.rd_next = 1'b1;
        end else cmd.op = imt_pkg::OP_PUSH;
      end
      S_SKIP: if (sts.rd_valid && sts.rd_lt_e) cmd.rd_next = 1'b1;
      S_POST: begin
        if (post_first_r && !endp_r) begin
          cmd.op = imt_pkg::OP_PUSH;
          cmd.push_end = 1'b1;
        end else if (sts.rd_valid) begin
          cmd.op = imt_pkg::OP_COPY;
          cmd.rd_next = 1'b1;
        end
      end
      S_CANON: begin
        // table index becomes the writeback address
        cmd.op = imt_pkg::OP_CANON;
        cmd.rd_clear = 1'b1;
      end
      S_WBACK: begin
        cmd.op = imt_pkg::OP_WBACK;
        if (sts.wb_done) cmd.commit = 1'b1;
      end
      S_DONE:  cmd.respond = 1'b1;
      S_FULL: begin
        cmd.respond = 1'b1;
        cmd.full    = 1'b1;
      end
      default: ;
    endcase
  end

  assign busy = state_r != S_IDLE;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> busy)
    else $error("start not taken");
  a_resp_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.respond |=> !cmd.respond)
    else $error("double result");
  a_full_assign: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.full |-> !sts.lookup)
    else $error("lookup flagged full");

endmodule
`default_nettype wire
